FILE: src/fat_chain_manager_macros.svh
// assertion macros for the file allocation table chain manager
// used by the top level only; no other dependencies
`ifndef FAT_CHAIN_MANAGER_MACROS_SVH
`define FAT_CHAIN_MANAGER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FAT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define FAT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/fat_pkg.sv
// shared types and codes for the file allocation table chain manager
// no dependencies
package fat_pkg;

   // operation kinds
   localparam logic [1:0] KIND_LOOKUP       = 2'd0;
   localparam logic [1:0] KIND_LOOKUP_ALLOC = 2'd1;
   localparam logic [1:0] KIND_FREE         = 2'd2;
   localparam logic [1:0] KIND_CLEAR        = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_CHAIN = 2'd1;
   localparam logic [1:0] ST_NO_SPACE = 2'd2;

   // link entry tags
   localparam logic [1:0] TAG_FREE = 2'd0;
   localparam logic [1:0] TAG_END  = 2'd1;
   localparam logic [1:0] TAG_LINK = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic       has_chain;
      logic [7:0] chain_head;
      logic [7:0] chain_pos;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] block;
      logic       head_valid;
      logic [7:0] new_head;
   } rsp_type;

   // finished operation handed from the sequencer to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } fin_type;

endpackage

FILE: src/fat_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
module fat_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fat_seq.sv
// sequencer for the chain manager: walks chains, scans for free blocks,
// frees chains and clears the table through one link table ram
// depends on fat_pkg and fat_ram
module fat_seq #(
   parameter int BLOCKS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fat_pkg::req_type req_payload,
   output fat_pkg::fin_type fin,
   input  logic             fin_take
);
   import fat_pkg::*;

   localparam int AW = $clog2(BLOCKS);
   localparam int EW = AW + 2;
   localparam int CW = AW + 1;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_WALK_RD  = 4'd2;
   localparam logic [3:0] S_WALK_CHK = 4'd3;
   localparam logic [3:0] S_SCAN_RD  = 4'd4;
   localparam logic [3:0] S_SCAN_CHK = 4'd5;
   localparam logic [3:0] S_LINK     = 4'd6;
   localparam logic [3:0] S_FREE_RD  = 4'd7;
   localparam logic [3:0] S_FREE_CHK = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic          reply_ff, reply_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [7:0]    cnt_ff, cnt_in;
   logic          grow_ff, grow_in;
   logic          for_head_ff, for_head_in;
   logic [7:0]    head_ff, head_in;
   logic          hv_ff, hv_in;
   rsp_type       res_ff, res_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic [1:0]    rd_tag;
   logic [AW-1:0] rd_idx;
   logic          head_bad;

   fat_ram #(
      .WIDTH(EW),
      .DEPTH(BLOCKS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_tag    = rd_data[EW-1:AW];
   assign rd_idx    = rd_data[AW-1:0];
   assign req_ready = (state_ff == S_IDLE);
   assign head_bad  = req_payload.has_chain &&
                      (32'(req_payload.chain_head) >= 32'(BLOCKS));
   assign fin.valid = (state_ff == S_FINISH);
   assign fin.rsp   = res_ff;

   // next-state and table access logic
   always_comb begin
      state_in    = state_ff;
      sp_in       = sp_ff;
      reply_in    = reply_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      grow_in     = grow_ff;
      for_head_in = for_head_ff;
      head_in     = head_ff;
      hv_in       = hv_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = cur_ff;
      wr_data     = '0;
      rd_addr     = cur_ff;

      case (state_ff)
         // clearing pass, one entry a cycle
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sp_ff[AW-1:0];
            wr_data = {TAG_FREE, {AW{1'b0}}};
            if (sp_ff == CW'(BLOCKS - 1)) begin
               sp_in    = '0;
               state_in = reply_ff ? S_FINISH : S_IDLE;
            end else begin
               sp_in = sp_ff + 1'b1;
            end
         end

         // take a new operation
         S_IDLE: begin
            if (req_valid) begin
               grow_in           = (req_payload.kind == KIND_LOOKUP_ALLOC);
               cnt_in            = req_payload.chain_pos;
               cur_in            = AW'(req_payload.chain_head);
               head_in           = req_payload.chain_head;
               hv_in             = req_payload.has_chain;
               for_head_in       = 1'b0;
               sp_in             = '0;
               reply_in          = 1'b0;
               res_in.status     = ST_OK;
               res_in.block      = 8'd0;
               res_in.head_valid = 1'b0;
               res_in.new_head   = 8'd0;
               if (req_payload.kind == KIND_CLEAR) begin
                  reply_in = 1'b1;
                  state_in = S_CLEAR;
               end else if (head_bad) begin
                  res_in.status     = ST_NO_CHAIN;
                  res_in.head_valid = 1'b1;
                  res_in.new_head   = req_payload.chain_head;
                  state_in          = S_FINISH;
               end else if (req_payload.kind == KIND_FREE) begin
                  state_in = req_payload.has_chain ? S_FREE_RD : S_FINISH;
               end else if (!req_payload.has_chain) begin
                  if (req_payload.kind == KIND_LOOKUP) begin
                     res_in.status = ST_NO_CHAIN;
                     state_in      = S_FINISH;
                  end else begin
                     for_head_in = 1'b1;
                     state_in    = S_SCAN_RD;
                  end
               end else begin
                  state_in = S_WALK_RD;
               end
            end
         end

         // walk one link, or finish at the wanted offset
         S_WALK_RD: begin
            if (cnt_ff == 8'd0) begin
               res_in.status     = ST_OK;
               res_in.block      = 8'(cur_ff);
               res_in.head_valid = 1'b1;
               res_in.new_head   = head_ff;
               state_in          = S_FINISH;
            end else begin
               rd_addr  = cur_ff;
               state_in = S_WALK_CHK;
            end
         end

         S_WALK_CHK: begin
            if (rd_tag == TAG_LINK) begin
               cur_in   = rd_idx;
               cnt_in   = cnt_ff - 8'd1;
               state_in = S_WALK_RD;
            end else if (!grow_ff) begin
               res_in.status     = ST_NO_CHAIN;
               res_in.head_valid = 1'b1;
               res_in.new_head   = head_ff;
               state_in          = S_FINISH;
            end else begin
               state_in = S_SCAN_RD;
            end
         end

         // start or restart the free block scan
         S_SCAN_RD: begin
            if (sp_ff == CW'(BLOCKS)) begin
               res_in.status     = ST_NO_SPACE;
               res_in.head_valid = hv_ff;
               res_in.new_head   = hv_ff ? head_ff : 8'd0;
               state_in          = S_FINISH;
            end else begin
               rd_addr  = sp_ff[AW-1:0];
               state_in = S_SCAN_CHK;
            end
         end

         // scan one entry a cycle, reading ahead while it is taken
         S_SCAN_CHK: begin
            if (rd_tag == TAG_FREE) begin
               wr_en   = 1'b1;
               wr_addr = sp_ff[AW-1:0];
               wr_data = {TAG_END, {AW{1'b0}}};
               if (for_head_ff) begin
                  head_in     = 8'(sp_ff);
                  hv_in       = 1'b1;
                  cur_in      = sp_ff[AW-1:0];
                  for_head_in = 1'b0;
                  sp_in       = sp_ff + 1'b1;
                  state_in    = S_WALK_RD;
               end else begin
                  state_in = S_LINK;
               end
            end else begin
               sp_in = sp_ff + 1'b1;
               if (sp_ff != CW'(BLOCKS - 1)) begin
                  rd_addr = AW'(sp_ff + 1'b1);
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end

         // link the chain end to the block just taken
         S_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = {TAG_LINK, sp_ff[AW-1:0]};
            cur_in   = sp_ff[AW-1:0];
            cnt_in   = cnt_ff - 8'd1;
            sp_in    = sp_ff + 1'b1;
            state_in = S_WALK_RD;
         end

         // free walk
         S_FREE_RD: begin
            rd_addr  = cur_ff;
            state_in = S_FREE_CHK;
         end

         S_FREE_CHK: begin
            if (rd_tag == TAG_FREE) begin
               state_in = S_FINISH;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {TAG_FREE, {AW{1'b0}}};
               if (rd_tag == TAG_LINK) begin
                  cur_in   = rd_idx;
                  state_in = S_FREE_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         // hand the result to the output stage
         S_FINISH: begin
            if (fin_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sp_ff    <= '0;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         reply_ff <= reply_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      grow_ff     <= grow_in;
      for_head_ff <= for_head_in;
      head_ff     <= head_in;
      hv_ff       <= hv_in;
      res_ff      <= res_in;
   end

endmodule

FILE: src/fat_chain_manager.sv
// top level of the file allocation table chain manager: sequencer and
// result register; depends on fat_pkg, fat_seq and the assertion macros
`include "fat_chain_manager_macros.svh"

// Keeps one link entry per block (free, end of chain or next block) in a
// BLOCKS-deep ram and serves one operation at a time; req_ready is low while
// an operation runs. All timing is set by the one link ram: a lookup reads
// and checks each link that it walks; each block taken by an allocating
// lookup adds a scan of one entry per cycle from just past the last block
// taken in this operation (from block 0 for the first) up to and including
// the free block found, which is then linked to the chain end unless it is
// the new head of a chain that had none; freeing a chain reads and clears
// each block in turn and stops at the chain end or at a free entry; clearing
// the table writes every entry. After reset a clearing pass runs before the
// first request is taken. The result sits in an output register, so the
// next request can be taken while it waits.
module fat_chain_manager #(
   parameter int BLOCKS = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fat_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fat_pkg::rsp_type rsp_payload
);
   import fat_pkg::*;

   fin_type fin;
   logic    fin_take;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;
   logic    req_fire;
   logic    status_known;
   logic    headless;
   logic    fields_zero;

   fat_seq #(
      .BLOCKS(BLOCKS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .fin        (fin),
      .fin_take   (fin_take)
   );

   // output register, refilled when empty or when its transfer completes
   assign fin_take = fin.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (fin_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = fin.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // terms for the checks
   assign req_fire     = req_valid && req_ready;
   assign status_known = (rsp_payload_ff.status == ST_OK) ||
                         (rsp_payload_ff.status == ST_NO_CHAIN) ||
                         (rsp_payload_ff.status == ST_NO_SPACE);
   assign headless     = rsp_valid_ff && !rsp_payload_ff.head_valid;
   assign fields_zero  = (rsp_payload_ff.block == 8'd0) && (rsp_payload_ff.new_head == 8'd0);

   // checks
   `FAT_ASSERT_NXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "ready after accept")
   `FAT_ASSERT_NXT(a_result_loaded, clock, reset, fin_take, rsp_valid_ff, "result not loaded")
   `FAT_ASSERT_IMP(a_status_code, clock, reset, rsp_valid_ff, status_known, "bad status")
   `FAT_ASSERT_IMP(a_no_head_no_block, clock, reset, headless, fields_zero, "block without head")

endmodule

FILE: bench/fat_chain_manager_tb.sv
// self-checking testbench for the file allocation table chain manager
// depends on fat_pkg and fat_chain_manager; drives a directed table, then random file traffic
module fat_chain_manager_tb;
   import fat_pkg::*;

   localparam int NBLK          = 256;
   localparam int PHASE_OPS     = 488;
   localparam int LIMIT_CYCLES  = 12_000_000;
   localparam int NFILES        = 8;

   // one directed step: the operation and, where typed, the result it must give
   typedef struct {
      req_type op;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   // shadow copy of the link table
   logic [1:0] tbl_tag  [NBLK];
   logic [7:0] tbl_next [NBLK];

   rsp_type      awaited_rsp[$];
   plan_row_type plan[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycles = 0;
   int unsigned ops_sent = 0;
   int unsigned rsp_seen = 0;
   int unsigned err_count = 0;
   int unsigned st_hist[3] = '{0, 0, 0};

   // tracked files for well-formed traffic
   logic       f_has  [NFILES];
   logic [7:0] f_head [NFILES];

   fat_chain_manager #(.BLOCKS(NBLK)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("** fat_chain_manager: FAILED **");
         $finish;
      end
   end

   function automatic void wipe_table();
      for (int i = 0; i < NBLK; i++) begin
         tbl_tag[i]  = TAG_FREE;
         tbl_next[i] = '0;
      end
   endfunction

   // lowest-numbered free block, marked end of chain; -1 when the table is full
   function automatic int grab_lowest_free();
      for (int i = 0; i < NBLK; i++) begin
         if (tbl_tag[i] == TAG_FREE) begin
            tbl_tag[i] = TAG_END;
            return i;
         end
      end
      return -1;
   endfunction

   // outcome of one operation on the shadow table
   function automatic rsp_type chain_outcome(req_type r);
      rsp_type    o;
      int         cur;
      int         nb;
      logic [1:0] was;
      logic [7:0] head;
      logic       grow;
      o    = '0;
      head = r.chain_head;
      grow = (r.kind == KIND_LOOKUP_ALLOC);
      if (r.kind == KIND_CLEAR) begin
         wipe_table();
         return o;
      end
      if (r.has_chain && int'(r.chain_head) >= NBLK) begin
         o.status     = ST_NO_CHAIN;
         o.head_valid = 1'b1;
         o.new_head   = r.chain_head;
         return o;
      end
      // free walks until end of chain or a free entry, so loops terminate
      if (r.kind == KIND_FREE) begin
         if (r.has_chain) begin
            cur = head;
            while (1) begin
               was = tbl_tag[cur];
               if (was == TAG_FREE) break;
               tbl_tag[cur] = TAG_FREE;
               if (was == TAG_END) break;
               cur = tbl_next[cur];
            end
         end
         return o;
      end
      if (!r.has_chain) begin
         if (!grow) begin
            o.status = ST_NO_CHAIN;
            return o;
         end
         nb = grab_lowest_free();
         if (nb < 0) begin
            o.status = ST_NO_SPACE;
            return o;
         end
         head = nb[7:0];
      end
      o.head_valid = 1'b1;
      o.new_head   = head;
      cur          = head;
      // walk to the offset, growing where the chain stops early
      for (int i = 0; i < int'(r.chain_pos); i++) begin
         if (tbl_tag[cur] != TAG_LINK) begin
            if (!grow) begin
               o.status = ST_NO_CHAIN;
               return o;
            end
            nb = grab_lowest_free();
            if (nb < 0) begin
               o.status = ST_NO_SPACE;
               return o;
            end
            tbl_tag[cur]  = TAG_LINK;
            tbl_next[cur] = nb[7:0];
            cur           = nb;
         end else begin
            cur = tbl_next[cur];
         end
      end
      o.block = cur[7:0];
      return o;
   endfunction

   function automatic plan_row_type mk_row(logic [1:0] k, logic h, int head, int off, bit typed,
                                           logic [1:0] st, int blk, logic hv, int nh);
      plan_row_type p;
      p.op.kind         = k;
      p.op.has_chain    = h;
      p.op.chain_head   = head[7:0];
      p.op.chain_pos    = off[7:0];
      p.typed           = typed;
      p.want.status     = st;
      p.want.block      = blk[7:0];
      p.want.head_valid = hv;
      p.want.new_head   = nh[7:0];
      return p;
   endfunction

   // offer one request, predict it on transfer, then maybe idle
   task automatic push_op(input req_type op, input bit typed, input rsp_type want,
                          output rsp_type pred);
      req_payload <= op;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pred = chain_outcome(op);
      awaited_rsp.push_back(typed ? want : pred);
      ops_sent++;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // drop valid and hold off until every outstanding result is back
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   // random traffic over a few files, with some noise mixed in
   task automatic run_phase(input int n, input int unsigned idle, input int unsigned stall);
      req_type op;
      rsp_type got;
      int      who;
      int      roll;
      int      sz;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int k = 0; k < n; k++) begin
         who  = $urandom_range(0, NFILES - 1);
         roll = $urandom_range(0, 99);
         sz   = $urandom_range(0, 99);
         op.has_chain  = f_has[who];
         op.chain_head = f_has[who] ? f_head[who] : 8'($urandom);
         if (sz < 80)
            op.chain_pos = 8'($urandom_range(0, 7));
         else if (sz < 95)
            op.chain_pos = 8'($urandom_range(8, 40));
         else
            op.chain_pos = 8'($urandom_range(128, 255));
         if (roll < 40)
            op.kind = KIND_LOOKUP_ALLOC;
         else if (roll < 72)
            op.kind = KIND_LOOKUP;
         else if (roll < 90)
            op.kind = KIND_FREE;
         else if (roll < 92)
            op.kind = KIND_CLEAR;
         else begin
            op  = req_type'($urandom);
            who = -1;
         end
         push_op(op, 1'b0, '0, got);
         // keep the tracked files in step with the table
         if (op.kind == KIND_CLEAR) begin
            for (int f = 0; f < NFILES; f++) f_has[f] = 1'b0;
         end else if (who >= 0) begin
            if (op.kind == KIND_FREE) begin
               f_has[who] = 1'b0;
            end else begin
               f_has[who]  = got.head_valid;
               f_head[who] = got.new_head;
            end
         end
      end
      drain();
   endtask

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (rsp_payload.status < 3) st_hist[rsp_payload.status]++;
         if (awaited_rsp.size() == 0) begin
            err_count++;
            $error("result transfer with nothing outstanding: %p", rsp_payload);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_payload.status !== want.status) begin
               err_count++;
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
            end
            if (rsp_payload.block !== want.block) begin
               err_count++;
               $error("block: expected %0d, got %0d", want.block, rsp_payload.block);
            end
            if (rsp_payload.head_valid !== want.head_valid) begin
               err_count++;
               $error("head_valid: expected %0d, got %0d", want.head_valid,
                      rsp_payload.head_valid);
            end
            if (rsp_payload.new_head !== want.new_head) begin
               err_count++;
               $error("new_head: expected %0d, got %0d", want.new_head, rsp_payload.new_head);
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // main sequence
   initial begin
      rsp_type got;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_ready   <= 1'b0;
      wipe_table();
      for (int f = 0; f < NFILES; f++) begin
         f_has[f]  = 1'b0;
         f_head[f] = '0;
      end

      // directed table: fresh table, growth, holes, shared links, full table
      plan.push_back(mk_row(KIND_LOOKUP,       0,   0,   0, 1, ST_NO_CHAIN, 0,   0, 0));
      plan.push_back(mk_row(KIND_FREE,         0,   0,   0, 1, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 0,   0,   0, 1, ST_OK,       0,   1, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 1,   0,   3, 1, ST_OK,       3,   1, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1,   0,   3, 1, ST_OK,       3,   1, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1,   0,   4, 1, ST_NO_CHAIN, 0,   1, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1,   0, 255, 1, ST_NO_CHAIN, 0,   1, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1, 200,   0, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1, 200,   1, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 1, 255,   2, 0, ST_OK,       0,   0, 0));
      // free from the middle leaves a hole, then growth relinks through it
      plan.push_back(mk_row(KIND_FREE,         1,   2,   0, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1,   0,   3, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 1,   0,   3, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_FREE,         1,   0,   0, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_CLEAR,        0,   0,   0, 1, ST_OK,       0,   0, 0));
      // fill the whole table, then run out of space
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 0,   0, 255, 1, ST_OK,     255,   1, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 0,   0,   0, 1, ST_NO_SPACE, 0,   0, 0));
      plan.push_back(mk_row(KIND_FREE,         1, 200,   0, 1, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 0,   0, 100, 1, ST_NO_SPACE, 0,   1, 200));
      plan.push_back(mk_row(KIND_LOOKUP,       1, 200,  55, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1, 200,  56, 1, ST_NO_CHAIN, 0,   1, 200));
      plan.push_back(mk_row(KIND_CLEAR,        0,   0,   0, 1, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP_ALLOC, 1, 255,   0, 0, ST_OK,       0,   0, 0));
      plan.push_back(mk_row(KIND_LOOKUP,       1, 170,  85, 1, ST_NO_CHAIN, 0,   1, 170));
      plan.push_back(mk_row(KIND_CLEAR,        0,   0,   0, 1, ST_OK,       0,   0, 0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) push_op(plan[i].op, plan[i].typed, plan[i].want, got);
      drain();

      // random traffic in four idling phases
      run_phase(PHASE_OPS, 0, 0);
      run_phase(PHASE_OPS, 53, 0);
      run_phase(PHASE_OPS, 0, 53);
      run_phase(PHASE_OPS, 23, 23);

      // let any late transfer show up
      repeat (NBLK + 50) @(posedge clock);

      $display("%0d operations sent, %0d results checked in %0d cycles", ops_sent, rsp_seen,
               cycles);
      $display("status mix: ok %0d, no chain %0d, no free block %0d", st_hist[0], st_hist[1],
               st_hist[2]);
      if (err_count == 0 && awaited_rsp.size() == 0)
         $display("** fat_chain_manager: PASSED **");
      else
         $display("** fat_chain_manager: FAILED **");
      $finish;
   end

endmodule
